// File: hdl/blpg_pkg.sv
// Shared constants, types and the sine table for the band-limited pulse generator.
// No dependencies; used by the top level and the testbench.
package blpg_pkg;

    localparam int TABLE_SIZE = 2048;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);

    // Configuration register indexes
    localparam logic [7:0] REG_BASE_INC  = 8'd0;
    localparam logic [7:0] REG_BASE_AMP  = 8'd1;
    localparam logic [7:0] REG_HARMONICS = 8'd2;
    localparam logic [7:0] REG_ENABLE    = 8'd3;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned QDEN    = 2 * TABLE_SIZE;

    typedef logic signed [15:0] t_sine_tab [TABLE_SIZE];

    // Sequencer states
    typedef enum logic [10:0] {
        S_FILL = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_READ = 11'b000_0000_0100,
        S_MA   = 11'b000_0000_1000,
        S_MB   = 11'b000_0001_0000,
        S_MU   = 11'b000_0010_0000,
        S_MN   = 11'b000_0100_0000,
        S_MD   = 11'b000_1000_0000,
        S_DS   = 11'b001_0000_0000,
        S_DIV  = 11'b010_0000_0000,
        S_PUT  = 11'b100_0000_0000
    } t_state;

    // sin((pi/2) * v / TABLE_SIZE) in Q1.15, Q2.30 working precision
    function automatic logic signed [15:0] quarter_sine(input longint unsigned v);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned r;
        begin
            x = (v * PI_Q30) / QDEN;
            x2 = (x * x) >> 30;
            // Horner steps of the Taylor series, highest term first
            t = ONE_Q30;
            t = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
            t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
            t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
            t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
            t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
            t = (x * t) >> 30;
            r = (t * 64'd32767 + (64'd1 << 29)) >> 30;
            return r[15:0];
        end
    endfunction

    // One full period, mirrored from the quarter wave
    function automatic t_sine_tab build_sine_table();
        t_sine_tab tab;
        longint unsigned tt;
        longint unsigned u;
        begin
            tt = TABLE_SIZE;
            for (int j = 0; j < TABLE_SIZE; j++) begin
                u = 4 * longint'(j);
                if (u <= tt)          tab[j] = quarter_sine(u);
                else if (u <= 2 * tt) tab[j] = quarter_sine(2 * tt - u);
                else if (u <= 3 * tt) tab[j] = -quarter_sine(u - 2 * tt);
                else                  tab[j] = -quarter_sine(4 * tt - u);
            end
            return tab;
        end
    endfunction

    localparam t_sine_tab SINE_TABLE = build_sine_table();

endpackage

// File: hdl/blpg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module blpg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bandlimited_pulse_generator.sv
// Band-limited pulse (buzz) generator, top level.
// Depends on blpg_pkg and blpg_ram (sine table).
// An enabled beat runs from acceptance to the output register through the table reads, 5 passes
// of the shared multiplier, a divider setup state, 32 steps of the radix-2 divider and the output
// state; the divider is skipped when the half-phase sine is zero, and a disabled beat goes straight to output.
// One beat at a time, ready again the cycle after the output loads; a stalled output holds the block.
// Reset (synchronous, active low) clears the phases and sets the configuration registers to defaults,
// then all TABLE_SIZE (2048) entries of the sine table are loaded before the first beat is taken.
module bandlimited_pulse_generator
    import blpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] freq_offset, [47:32] amp_offset
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] sample
);

    t_state r_state, n_state;

    // configuration and phases
    logic [31:0] r_base_inc;
    logic [14:0] r_base_amp;
    logic [7:0]  r_harm;
    logic        r_enable;
    logic [31:0] r_up_ph, n_up_ph;
    logic [31:0] r_hf_ph, n_hf_ph;

    // per-beat working registers
    logic [31:0]        r_f;
    logic [14:0]        r_amp;
    logic [2:0]         r_step;
    logic [ADDR_W-1:0]  r_fill;
    logic signed [15:0] r_s [4];
    logic signed [15:0] r_a, r_b;
    logic signed [50:0] r_prod;
    logic signed [32:0] r_num;
    logic [32:0]        r_rem;
    logic [31:0]        r_quo;
    logic [31:0]        r_dvs;
    logic               r_neg;
    logic [4:0]         r_cnt;
    logic signed [15:0] r_res;
    logic               r_out_valid;
    logic signed [15:0] r_out;

    // sine table
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    blpg_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_SIZE)
    ) u_sine (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill),
        .i_wdata (SINE_TABLE[r_fill]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_we = (r_state == S_FILL);

    // handshakes
    logic in_beat, out_beat, cfg_beat, out_free;
    assign o_cfg_ready   = 1'b1;
    assign cfg_beat      = i_cfg_valid;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = r_out_valid && m_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // harmonic count, zero treated as one
    logic [7:0] n_eff;
    assign n_eff = (r_harm == 8'd0) ? 8'd1 : r_harm;

    // amplitude sum, saturated to 0..32767
    logic signed [17:0] amp_sum;
    logic [14:0]        amp_sat;
    assign amp_sum = $signed({3'b000, r_base_amp}) + 18'($signed(s_axis_tdata[47:32]));
    always_comb begin
        if (amp_sum < 18'sd0)          amp_sat = 15'd0;
        else if (amp_sum > 18'sd32767) amp_sat = 15'h7fff;
        else                           amp_sat = amp_sum[14:0];
    end

    // table read address sequence: upper idx, idx+1, half idx, idx+1
    logic [ADDR_W-1:0] up_idx, hf_idx;
    assign up_idx = r_up_ph[31 -: ADDR_W];
    assign hf_idx = r_hf_ph[31 -: ADDR_W];
    always_comb begin
        case (r_step[1:0])
            2'd0:    ram_raddr = up_idx;
            2'd1:    ram_raddr = up_idx + 1'b1;
            2'd2:    ram_raddr = hf_idx;
            default: ram_raddr = hf_idx + 1'b1;
        endcase
    end

    // shared multiplier operand selection
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic [15:0]        f16_up, f16_hf;
    logic signed [15:0] interp;
    assign f16_up = r_up_ph[31-ADDR_W -: 16];
    assign f16_hf = r_hf_ph[31-ADDR_W -: 16];
    always_comb begin
        case (r_state)
            S_MA: begin
                mul_a = 33'(r_s[1] - r_s[0]);
                mul_b = $signed({2'b00, f16_up});
            end
            S_MB: begin
                mul_a = 33'(r_s[3] - r_s[2]);
                mul_b = $signed({2'b00, f16_hf});
            end
            S_MU: begin
                mul_a = $signed({1'b0, r_f});
                mul_b = $signed({9'd0, n_eff, 1'b1});
            end
            S_MN: begin
                mul_a = 33'(r_a - r_b);
                mul_b = $signed({3'b000, r_amp});
            end
            default: begin
                mul_a = 33'(r_b);
                mul_b = $signed({9'd0, n_eff, 1'b0});
            end
        endcase
    end

    // interpolation: s0 + floor(prod / 65536)
    logic signed [15:0] s_base;
    assign s_base = (r_state == S_MB) ? r_s[0] : r_s[2];
    assign interp = 16'(s_base + 16'(r_prod >>> 16));

    // divider step and magnitudes
    logic [32:0] div_try;
    logic [32:0] div_sub;
    logic [31:0] quo_nxt;
    logic [31:0] num_mag, den_mag;
    logic signed [32:0] den_val;
    assign div_try = {r_rem[31:0], r_quo[31]};
    assign div_sub = div_try - {1'b0, r_dvs};
    assign quo_nxt = {r_quo[30:0], ~div_sub[32]};
    assign den_val = r_prod[32:0];
    assign num_mag = r_num[32] ? 32'(-r_num) : r_num[31:0];
    assign den_mag = den_val[32] ? 32'(-den_val) : den_val[31:0];

    // quotient limit and sign, taken from the quotient including this step's bit
    logic [14:0]        q_lim;
    logic signed [15:0] q_fin;
    assign q_lim = (quo_nxt > {17'd0, r_amp}) ? r_amp : quo_nxt[14:0];
    assign q_fin = r_neg ? -$signed({1'b0, q_lim}) : $signed({1'b0, q_lim});

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FILL: if (r_fill == ADDR_W'(TABLE_SIZE - 1)) n_state = S_IDLE;
            S_IDLE: if (in_beat) n_state = r_enable ? S_READ : S_PUT;
            S_READ: if (r_step == 3'd4) n_state = S_MA;
            S_MA:   n_state = S_MB;
            S_MB:   n_state = S_MU;
            S_MU:   n_state = S_MN;
            S_MN:   n_state = S_MD;
            S_MD:   n_state = S_DS;
            S_DS:   n_state = (r_b == 16'sd0) ? S_PUT : S_DIV;
            S_DIV:  if (r_cnt == 5'd31) n_state = S_PUT;
            S_PUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // phase update, harmonic write clears both
    always_comb begin
        n_up_ph = r_up_ph;
        n_hf_ph = r_hf_ph;
        if (r_state == S_MN) begin
            n_up_ph = r_up_ph + r_prod[32:1];
            n_hf_ph = r_hf_ph + {1'b0, r_f[31:1]};
        end
        if (cfg_beat && i_cfg_index == REG_HARMONICS) begin
            n_up_ph = '0;
            n_hf_ph = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_fill      <= '0;
            r_step      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_up_ph     <= '0;
            r_hf_ph     <= '0;
            r_base_inc  <= 32'd42852281;
            r_base_amp  <= 15'd32767;
            r_harm      <= 8'd10;
            r_enable    <= 1'b1;
        end else begin
            r_state <= n_state;
            r_up_ph <= n_up_ph;
            r_hf_ph <= n_hf_ph;
            if (r_state == S_FILL) r_fill <= r_fill + 1'b1;
            if (r_state == S_READ) r_step <= r_step + 1'b1;
            else                   r_step <= '0;
            if (r_state == S_DIV)  r_cnt <= r_cnt + 1'b1;
            else                   r_cnt <= '0;
            if (r_state == S_PUT && out_free) r_out_valid <= 1'b1;
            else if (out_beat)                r_out_valid <= 1'b0;
            if (cfg_beat) begin
                case (i_cfg_index)
                    REG_BASE_INC:  r_base_inc <= i_cfg_data;
                    REG_BASE_AMP:  r_base_amp <= i_cfg_data[14:0];
                    REG_HARMONICS: r_harm     <= i_cfg_data[7:0];
                    REG_ENABLE:    r_enable   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_f   <= r_base_inc + s_axis_tdata[31:0];
            r_amp <= amp_sat;
            r_res <= 16'sd0;
        end
        if (r_state == S_READ && r_step != 3'd0) begin
            r_s[2'(r_step - 3'd1)] <= ram_rdata;
        end
        if (r_state == S_MA || r_state == S_MB || r_state == S_MU ||
            r_state == S_MN || r_state == S_MD) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_MB) r_a <= interp;
        if (r_state == S_MU) r_b <= interp;
        if (r_state == S_MD) r_num <= r_prod[32:0];
        if (r_state == S_DS) begin
            r_rem <= '0;
            r_quo <= num_mag;
            r_dvs <= den_mag;
            r_neg <= r_num[32] ^ den_val[32];
            r_res <= $signed({1'b0, r_amp});
        end
        if (r_state == S_DIV) begin
            if (!div_sub[32]) begin
                r_rem <= div_sub;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= div_try;
                r_quo <= {r_quo[30:0], 1'b0};
            end
            if (r_cnt == 5'd31) r_res <= q_fin;
        end
        if (r_state == S_PUT && out_free) r_out <= r_res;
    end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for bandlimited_pulse_generator: predicts each sample and compares.
// Depends on blpg_pkg (register indexes, TABLE_SIZE) and the generator RTL.
module tb_top
    import blpg_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [31:0] freq_offset, [47:32] amp_offset
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] sample

    bandlimited_pulse_generator dut (.*);

    // predictor state
    logic signed [15:0] sine_tab [TABLE_SIZE];
    logic [31:0] up_ph, hf_ph, base_inc;
    logic [14:0] base_amp;
    logic [7:0]  harmonics;
    logic        gen_on;

    logic [47:0]        beat_q [$];
    logic signed [15:0] sample_q [$];
    int   errors;
    int   samples_seen;
    int   send_idle, recv_idle;
    bit   cfg_busy;

    // table built independently: Taylor series on the quarter wave, then mirrored
    function automatic logic signed [15:0] qsin(longint unsigned v);
        longint unsigned x, x2, t;
        longint unsigned dv [5];
        dv = '{110, 72, 42, 20, 6};
        x  = (v * 64'd3373259426) / (2 * TABLE_SIZE);
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int k = 0; k < 5; k++) t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[k];
        t = (x * t) >> 30;
        return 16'((t * 32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic longint interp_sine(logic [31:0] ph);
        logic [42:0] p;
        longint s0, s1, d;
        p  = 43'(ph) * TABLE_SIZE;
        s0 = sine_tab[p[42:32]];
        s1 = sine_tab[11'(p[42:32] + 1)];
        d  = (s1 - s0) * longint'({1'b0, p[31:16]});
        return s0 + (d >>> 16);
    endfunction

    // next sample from one input beat; advances phases when enabled
    function automatic logic signed [15:0] next_sample(logic [47:0] bt);
        longint n, amp, a, b, q;
        logic [31:0] f;
        if (!gen_on) return 16'sd0;
        n   = (harmonics == 0) ? 1 : harmonics;
        f   = base_inc + bt[31:0];
        amp = longint'(base_amp) + longint'($signed(bt[47:32]));
        if (amp < 0) amp = 0;
        if (amp > 32767) amp = 32767;
        a = interp_sine(up_ph);
        b = interp_sine(hf_ph);
        up_ph = up_ph + 32'((longint'(f) * (2 * n + 1)) >> 1);
        hf_ph = hf_ph + (f >> 1);
        if (b == 0) q = amp;
        else begin
            q = (amp * (a - b)) / (2 * n * b);
            if (q > amp) q = amp;
            if (q < -amp) q = -amp;
        end
        return 16'(q);
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

    // driver: one beat from the queue, predicting on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sample_q.push_back(next_sample(s_axis_tdata));
                void'(beat_q.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold
            end else if (beat_q.size() > 0
                         && !cfg_busy && $urandom_range(99) >= send_idle) begin
                s_axis_tvalid <= 1;
                s_axis_tdata  <= beat_q[0];
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // monitor and output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                samples_seen++;
                if (sample_q.size() == 0) report("unexpected sample", m_axis_tdata, 16'h0);
                else begin
                    if (m_axis_tdata !== sample_q[0])
                        report("sample", m_axis_tdata, sample_q[0]);
                    void'(sample_q.pop_front());
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic wait_idle();
        while (beat_q.size() != 0 || s_axis_tvalid || sample_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // model write happens on the accepting edge
    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            REG_BASE_INC:  base_inc = val;
            REG_BASE_AMP:  base_amp = val[14:0];
            REG_HARMONICS: begin
                harmonics = val[7:0];
                up_ph = 0;
                hf_ph = 0;
            end
            REG_ENABLE:    gen_on = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_beat(int mode);
        logic [31:0] fo;
        logic [15:0] ao;
        case (mode)
            0: fo = $urandom;
            1: fo = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default: fo = 0;
        endcase
        ao = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
        return {ao, fo};
    endfunction

    task automatic run_phase(int count, int mode);
        for (int k = 0; k < count; k++) beat_q.push_back(rand_beat(mode));
        wait_idle();
    endtask

    initial begin
        for (int j = 0; j < TABLE_SIZE; j++) begin
            if (4 * j <= TABLE_SIZE) sine_tab[j] = qsin(4 * j);
            else if (4 * j <= 2 * TABLE_SIZE) sine_tab[j] = qsin(2 * TABLE_SIZE - 4 * j);
            else if (4 * j <= 3 * TABLE_SIZE) sine_tab[j] = -qsin(4 * j - 2 * TABLE_SIZE);
            else sine_tab[j] = -qsin(4 * TABLE_SIZE - 4 * j);
        end
        up_ph = 0; hf_ph = 0; base_inc = 32'd42852281; base_amp = 15'h7fff;
        harmonics = 8'd10; gen_on = 1;
        errors = 0; samples_seen = 0; send_idle = 16; recv_idle = 46; cfg_busy = 0;
        i_rst_n = 0; i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: field extremes, saturating amplitude, zero offsets
        beat_q.push_back({16'sh0000, 32'h0});
        beat_q.push_back({16'sh7fff, 32'h7fff_ffff});
        beat_q.push_back({16'sh8000, 32'h8000_0000});
        beat_q.push_back({16'shffff, 32'hffff_ffff});
        beat_q.push_back({16'sh0001, 32'h0000_0001});
        beat_q.push_back({16'sh8001, 32'h1234_5678});
        wait_idle();
        // harmonic count zero and the extremes; out-of-range index ignored
        write_reg(REG_HARMONICS, 0);
        run_phase(4, 2);
        write_reg(REG_HARMONICS, 255);
        write_reg(REG_BASE_AMP, 0);
        run_phase(4, 1);
        write_reg(8'd7, 32'hffff_ffff);
        write_reg(REG_BASE_INC, 32'hffff_ffff);
        write_reg(REG_BASE_AMP, 32'h7fff);
        write_reg(REG_HARMONICS, 1);
        run_phase(4, 0);
        // disabled: zero out, phases hold
        write_reg(REG_ENABLE, 0);
        run_phase(4, 0);
        write_reg(REG_ENABLE, 1);
        write_reg(REG_BASE_INC, 0);
        run_phase(3, 2);

        // random phases over several settings
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin send_idle = 46; recv_idle = 16; end
            if (ph == 8) begin send_idle = 0; recv_idle = 0; end
            write_reg(REG_BASE_INC, (ph % 3 == 0) ? $urandom : $urandom_range(0, 32'h0800_0000));
            write_reg(REG_BASE_AMP, (ph == 5) ? 0 : $urandom_range(0, 32767));
            write_reg(REG_HARMONICS, (ph == 2) ? 255 : $urandom_range(0, 40));
            write_reg(REG_ENABLE, (ph == 6) ? 0 : 1);
            run_phase(140, (ph % 4 == 0) ? 0 : 1);
        end

        $display("covered %0d samples over directed extremes and 12 register settings",
                 samples_seen);
        $display("harmonics 0..255, disabled phases, saturated amplitudes, both stall mixes");
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: filelist.f
hdl/blpg_pkg.sv
hdl/blpg_ram.sv
hdl/bandlimited_pulse_generator.sv
sim/tb_top.sv
